// ----- rtl/penetration_point_ratio_unit_assert.svh -----
// Assertion macros shared by the checker files of the penetration point ratio unit.
// No dependencies; include by bare file name.
`ifndef PENETRATION_POINT_RATIO_UNIT_ASSERT_SVH
`define PENETRATION_POINT_RATIO_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ppr_pkg.sv -----
// Package for the penetration point ratio unit: widths, register indexes, reset values,
// datapath op codes and the control/status structs. No dependencies.
package ppr_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgW    = 31;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned GainW   = 10;
  localparam int unsigned DvdW    = 63;  // divider dividend / quotient magnitude
  localparam int unsigned DvsW    = 33;  // divider divisor magnitude
  localparam int unsigned CntW    = 6;
  localparam int unsigned ClampW  = 41;  // magnitude up to 2^40

  localparam logic [CfgIdxW-1:0] CfgFirstDepth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondDepth = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFirstRef    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSecondRef   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgUseArea     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPistonArea  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgAreaGain    = 3'd6;

  localparam logic [CfgW-1:0]  FirstDepthRst  = 31'd166461;
  localparam logic [CfgW-1:0]  SecondDepthRst = 31'd332923;
  localparam logic [CfgW-1:0]  FirstRefRst    = 31'd865075;
  localparam logic [CfgW-1:0]  SecondRefRst   = 31'd1310720;
  localparam logic [CfgW-1:0]  PistonAreaRst  = 31'd65536;
  localparam logic [GainW-1:0] AreaGainRst    = 10'd1;

  localparam logic [ClampW-1:0] Lim40    = 41'h100_0000_0000;
  localparam logic [6:0]        PctMul   = 7'd100;  // 6553600 = 100 << 16
  localparam logic [DataW-1:0]  SatMax   = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0]  SatMin   = 32'h8000_0000;

  typedef enum logic [3:0] {
    OpNone,
    OpLoad,
    OpHistClear,
    OpHistUpdate,
    OpMulNum,
    OpDivNum,
    OpAdd,
    OpAreaMul,
    OpDivArea,
    OpXFromP,
    OpXFromQ,
    OpRatioMul,
    OpDivRatio,
    OpRatioFromQ,
    OpSatSign,
    OpOutLoad
  } ppr_op_e;

  typedef struct packed {
    logic [CfgW-1:0]  first_depth;
    logic [CfgW-1:0]  second_depth;
    logic [CfgW-1:0]  first_reference;
    logic [CfgW-1:0]  second_reference;
    logic             use_area;
    logic [CfgW-1:0]  piston_area;
    logic [GainW-1:0] area_gain;
  } ppr_cfg_t;

  typedef struct packed {
    ppr_op_e op;
    logic    pt;   // 0: first depth, 1: second depth
  } ppr_cmd_t;

  typedef struct packed {
    logic det1;
    logic det2;
    logic rearm;
    logic use_area;
    logic den_zero;
    logic area_zero;
    logic ref_zero;
    logic div_done;
  } ppr_sts_t;

endpackage

// ----- rtl/ppr_div.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on ppr_pkg for widths.
module ppr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ppr_pkg::DvdW-1:0]  dividend_i,
  input  logic [ppr_pkg::DvsW-1:0]  divisor_i,
  output logic [ppr_pkg::DvdW-1:0]  quotient_o,
  output logic                      done_o
);
  import ppr_pkg::*;

  logic [DvdW-1:0] acc_q, acc_d;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DvsW:0]   rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q, acc_q[DvdW-1]};
    trial  = rem_sh - {1'b0, dvs_q};
    if (!trial[DvsW]) begin
      rem_d = trial[DvsW-1:0];
      acc_d = {acc_q[DvdW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[DvsW-1:0];
      acc_d = {acc_q[DvdW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = acc_q;
  assign done_o     = done_q;

endmodule

// ----- rtl/ppr_dp.sv -----
// Datapath of the penetration point ratio unit: sample history, interpolation operands,
// sign-magnitude scaling and the shared divider. Depends on ppr_pkg and ppr_div.
module ppr_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ppr_pkg::ppr_cfg_t        cfg_i,
  input  ppr_pkg::ppr_cmd_t        cmd_i,
  input  logic [ppr_pkg::DataW-1:0] displacement_i,
  input  logic [ppr_pkg::DataW-1:0] load_i,
  input  logic                     rearm_i,
  output ppr_pkg::ppr_sts_t        sts_o,
  output logic [ppr_pkg::DataW-1:0] first_ratio_o,
  output logic [ppr_pkg::DataW-1:0] second_ratio_o
);
  import ppr_pkg::*;

  logic [DataW-1:0]  d_q, l_q, prev_d_q, prev_l_q;
  logic              rearm_q;
  logic [DvsW-1:0]   den_mag_q;
  logic              den_neg_q;
  logic [DvdW-1:0]   dvd_q;
  logic              sgn_q;
  logic [DataW-1:0]  p_q;
  logic [ClampW-1:0] x_mag_q;
  logic [DataW-1:0]  r1_q, r2_q, first_ratio_q, second_ratio_q;

  logic [CfgW-1:0]   depth, refv;
  logic [DvsW-1:0]   diff_a, diff_b, b_mag, den_diff;
  logic [CfgW-1:0]   a_mag;
  logic [63:0]       num_prod;
  logic              num_neg;
  logic [DvdW-1:0]   qm;
  logic              q_big;
  logic [ClampW-1:0] qc;
  logic [ClampW:0]   qs, l_ext, sum;
  logic [DataW-1:0]  p_sat;
  logic [DataW-1:0]  p_mag;
  logic [41:0]       gprod;
  logic [47:0]       rprod;
  logic [DataW-1:0]  ratio_fin;
  logic              div_start, div_done;
  logic [DvsW-1:0]   divisor;

  always_comb begin
    depth = cmd_i.pt ? cfg_i.second_depth : cfg_i.first_depth;
    refv  = cmd_i.pt ? cfg_i.second_reference : cfg_i.first_reference;

    // d >= depth when this runs, so d - depth is a 31-bit magnitude
    diff_a   = {d_q[DataW-1], d_q} - {2'b00, depth};
    a_mag    = diff_a[CfgW-1:0];
    diff_b   = {l_q[DataW-1], l_q} - {prev_l_q[DataW-1], prev_l_q};
    b_mag    = diff_b[DvsW-1] ? (~diff_b + 1'b1) : diff_b;
    num_prod = a_mag * b_mag;
    // num = -(d - depth) * (l - lp): negative only for a nonzero product with l > lp
    num_neg  = !diff_b[DvsW-1] && (num_prod != 64'd0);
    den_diff = {d_q[DataW-1], d_q} - {prev_d_q[DataW-1], prev_d_q};

    qm    = quotient_w;
    q_big = (qm > DvdW'(Lim40));
    qc    = q_big ? Lim40 : qm[ClampW-1:0];

    qs    = sgn_q ? (~{1'b0, qc} + 1'b1) : {1'b0, qc};
    l_ext = {{(ClampW+1-DataW){l_q[DataW-1]}}, l_q};
    sum   = qs + l_ext;
    if (!sum[ClampW] && (sum[ClampW-1:DataW-1] != '0)) begin
      p_sat = SatMax;
    end else if (sum[ClampW] && (sum[ClampW-1:DataW-1] != '1)) begin
      p_sat = SatMin;
    end else begin
      p_sat = sum[DataW-1:0];
    end

    p_mag = p_q[DataW-1] ? (~p_q + 1'b1) : p_q;
    gprod = p_mag * cfg_i.area_gain;
    rprod = x_mag_q * PctMul;

    if (sgn_q) begin
      ratio_fin = (qm > DvdW'(SatMin)) ? SatMin : (~qm[DataW-1:0] + 1'b1);
    end else begin
      ratio_fin = (qm > DvdW'(SatMax)) ? SatMax : qm[DataW-1:0];
    end

    div_start = 1'b0;
    divisor   = den_mag_q;
    unique case (cmd_i.op)
      OpDivNum: begin
        div_start = 1'b1;
      end
      OpDivArea: begin
        div_start = 1'b1;
        divisor   = {2'b00, cfg_i.piston_area};
      end
      OpDivRatio: begin
        div_start = 1'b1;
        divisor   = {2'b00, refv};
      end
      default: ;
    endcase
  end

  logic [DvdW-1:0] quotient_w;

  ppr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_q),
    .divisor_i  (divisor),
    .quotient_o (quotient_w),
    .done_o     (div_done)
  );

  // sample history is block state and resets to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_d_q <= '0;
      prev_l_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OpHistClear: begin
          prev_d_q <= '0;
          prev_l_q <= '0;
        end
        OpHistUpdate: begin
          prev_d_q <= d_q;
          prev_l_q <= l_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpLoad: begin
        d_q     <= displacement_i;
        l_q     <= load_i;
        rearm_q <= rearm_i;
        r1_q    <= '0;
        r2_q    <= '0;
      end
      OpMulNum: begin
        dvd_q     <= num_prod[DvdW-1:0];
        sgn_q     <= num_neg;
        den_neg_q <= den_diff[DvsW-1];
        den_mag_q <= den_diff[DvsW-1] ? (~den_diff + 1'b1) : den_diff;
      end
      OpDivNum: begin
        sgn_q <= sgn_q ^ den_neg_q;
      end
      OpAdd: begin
        p_q <= p_sat;
      end
      OpAreaMul: begin
        dvd_q <= {5'b0_0000, gprod, 16'h0000};
        sgn_q <= p_q[DataW-1] && (gprod != 42'd0);
      end
      OpXFromP: begin
        x_mag_q <= {{(ClampW-DataW){1'b0}}, p_mag};
        sgn_q   <= p_q[DataW-1];
      end
      OpXFromQ: begin
        x_mag_q <= qc;
        sgn_q   <= sgn_q && (qc != '0);
      end
      OpRatioMul: begin
        dvd_q <= {rprod[46:0], 16'h0000};
      end
      OpRatioFromQ: begin
        if (cmd_i.pt) r2_q <= ratio_fin;
        else          r1_q <= ratio_fin;
      end
      OpSatSign: begin
        if (cmd_i.pt) r2_q <= sgn_q ? SatMin : SatMax;
        else          r1_q <= sgn_q ? SatMin : SatMax;
      end
      OpOutLoad: begin
        first_ratio_q  <= r1_q;
        second_ratio_q <= r2_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.det1      = $signed(d_q) >= $signed({1'b0, cfg_i.first_depth});
    sts_o.det2      = $signed(d_q) >= $signed({1'b0, cfg_i.second_depth});
    sts_o.rearm     = rearm_q;
    sts_o.use_area  = cfg_i.use_area;
    sts_o.den_zero  = (den_mag_q == '0);
    sts_o.area_zero = (cfg_i.piston_area == '0);
    sts_o.ref_zero  = (refv == '0);
    sts_o.div_done  = div_done;
  end

  assign first_ratio_o  = first_ratio_q;
  assign second_ratio_o = second_ratio_q;

endmodule

// ----- rtl/ppr_ctrl.sv -----
// Controller of the penetration point ratio unit: handshakes, found flags and op sequencing.
// Depends on ppr_pkg for the command/status structs.
module ppr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              first_valid_o,
  output logic              second_valid_o,
  output logic              all_found_o,
  input  ppr_pkg::ppr_sts_t sts_i,
  output ppr_pkg::ppr_cmd_t cmd_o
);
  import ppr_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SEval, SMul, SDen, SDiv1, SXsel, SArea, SDiv2,
    SRef, SRstart, SDiv3, SNext, SFin, SOut
  } state_e;

  state_e state_q;
  logic   pt_q, det1_q, det2_q;
  logic   first_found_q, second_found_q, both_found_q;
  logic   out_valid_q, first_valid_q, second_valid_q, all_found_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.pt = pt_q;
    cmd_o.op = OpNone;
    unique case (state_q)
      SIdle:   if (in_valid_i) cmd_o.op = OpLoad;
      SEval:   if (both_found_q) cmd_o.op = OpHistClear;
      SMul:    cmd_o.op = OpMulNum;
      SDen:    cmd_o.op = sts_i.den_zero ? OpSatSign : OpDivNum;
      SDiv1:   if (sts_i.div_done) cmd_o.op = OpAdd;
      SXsel:   cmd_o.op = sts_i.use_area ? OpAreaMul : OpXFromP;
      SArea:   cmd_o.op = sts_i.area_zero ? OpSatSign : OpDivArea;
      SDiv2:   if (sts_i.div_done) cmd_o.op = OpXFromQ;
      SRef:    cmd_o.op = sts_i.ref_zero ? OpSatSign : OpRatioMul;
      SRstart: cmd_o.op = OpDivRatio;
      SDiv3:   if (sts_i.div_done) cmd_o.op = OpRatioFromQ;
      SFin:    cmd_o.op = OpHistUpdate;
      SOut:    if (out_free) cmd_o.op = OpOutLoad;
      default: cmd_o.op = OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= SIdle;
      pt_q           <= 1'b0;
      det1_q         <= 1'b0;
      det2_q         <= 1'b0;
      first_found_q  <= 1'b0;
      second_found_q <= 1'b0;
      both_found_q   <= 1'b0;
      out_valid_q    <= 1'b0;
      first_valid_q  <= 1'b0;
      second_valid_q <= 1'b0;
      all_found_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (in_valid_i) state_q <= SEval;
        end
        SEval: begin
          if (both_found_q) begin
            first_found_q  <= 1'b0;
            second_found_q <= 1'b0;
            if (sts_i.rearm) both_found_q <= 1'b0;
            det1_q  <= 1'b0;
            det2_q  <= 1'b0;
            state_q <= SOut;
          end else begin
            det1_q <= !first_found_q && sts_i.det1;
            det2_q <= !second_found_q && sts_i.det2;
            if (!first_found_q && sts_i.det1) begin
              pt_q    <= 1'b0;
              state_q <= SMul;
            end else if (!second_found_q && sts_i.det2) begin
              pt_q    <= 1'b1;
              state_q <= SMul;
            end else begin
              state_q <= SFin;
            end
          end
        end
        SMul: state_q <= SDen;
        SDen: state_q <= sts_i.den_zero ? SNext : SDiv1;
        SDiv1: begin
          if (sts_i.div_done) state_q <= SXsel;
        end
        SXsel: state_q <= sts_i.use_area ? SArea : SRef;
        SArea: state_q <= sts_i.area_zero ? SNext : SDiv2;
        SDiv2: begin
          if (sts_i.div_done) state_q <= SRef;
        end
        SRef:    state_q <= sts_i.ref_zero ? SNext : SRstart;
        SRstart: state_q <= SDiv3;
        SDiv3: begin
          if (sts_i.div_done) state_q <= SNext;
        end
        SNext: begin
          if (!pt_q && det2_q) begin
            pt_q    <= 1'b1;
            state_q <= SMul;
          end else begin
            state_q <= SFin;
          end
        end
        SFin: begin
          first_found_q  <= first_found_q | det1_q;
          second_found_q <= second_found_q | det2_q;
          both_found_q   <= (first_found_q | det1_q) & (second_found_q | det2_q);
          state_q        <= SOut;
        end
        SOut: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            first_valid_q  <= det1_q;
            second_valid_q <= det2_q;
            all_found_q    <= both_found_q;
            state_q        <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign in_ready_o     = (state_q == SIdle);
  assign out_valid_o    = out_valid_q;
  assign first_valid_o  = first_valid_q;
  assign second_valid_o = second_valid_q;
  assign all_found_o    = all_found_q;

endmodule

// ----- rtl/penetration_point_ratio_unit.sv -----
// Top level of the penetration point ratio unit: configuration registers, controller and
// datapath. Depends on ppr_pkg, ppr_ctrl, ppr_dp (and ppr_div below it).
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) transfers one displacement/load sample plus
//    rearm; output channel (out_valid_o/out_ready_i) transfers exactly one result per input.
//  - Items are processed one at a time. in_ready_o is high only while the unit is idle.
//  - Latency from input transfer to out_valid_o is shortest when no depth is crossed; each
//    crossing adds to it, more with area conversion, so the worst case is both depths
//    crossed on one item with area on.
//  - The cost is set by the shared restoring divider: one division for the interpolation,
//    one for the area, one for the percentage.
//  - The output register decouples the two sides: a new item is taken while a finished
//    result waits; the following result waits in the controller until the receiver takes
//    the held one, and no input is taken meanwhile.
//  - Reset (rst_ni low, asynchronous) restores register defaults, clears history and the
//    found flags, and drops out_valid_o.
//  - cfg_we_i writes register cfg_idx_i; indexes beyond the list are ignored.
//    Write only while idle.
module penetration_point_ratio_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ppr_pkg::DataW-1:0]    displacement_i,
  input  logic [ppr_pkg::DataW-1:0]    load_i,
  input  logic                         rearm_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         first_valid_o,
  output logic [ppr_pkg::DataW-1:0]    first_ratio_o,
  output logic                         second_valid_o,
  output logic [ppr_pkg::DataW-1:0]    second_ratio_o,
  output logic                         all_found_o,
  input  logic                         cfg_we_i,
  input  logic [ppr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ppr_pkg::CfgW-1:0]     cfg_wdata_i
);
  import ppr_pkg::*;

  ppr_cfg_t cfg_q;
  ppr_cmd_t cmd;
  ppr_sts_t sts;

  // register bank; field widths truncate the write data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_depth      <= FirstDepthRst;
      cfg_q.second_depth     <= SecondDepthRst;
      cfg_q.first_reference  <= FirstRefRst;
      cfg_q.second_reference <= SecondRefRst;
      cfg_q.use_area         <= 1'b0;
      cfg_q.piston_area      <= PistonAreaRst;
      cfg_q.area_gain        <= AreaGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFirstDepth:  cfg_q.first_depth      <= cfg_wdata_i;
        CfgSecondDepth: cfg_q.second_depth     <= cfg_wdata_i;
        CfgFirstRef:    cfg_q.first_reference  <= cfg_wdata_i;
        CfgSecondRef:   cfg_q.second_reference <= cfg_wdata_i;
        CfgUseArea:     cfg_q.use_area         <= cfg_wdata_i[0];
        CfgPistonArea:  cfg_q.piston_area      <= cfg_wdata_i;
        CfgAreaGain:    cfg_q.area_gain        <= cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // sequencing: flags, handshakes, op per cycle
  ppr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .first_valid_o  (first_valid_o),
    .second_valid_o (second_valid_o),
    .all_found_o    (all_found_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // arithmetic: interpolation, area scaling, percentage, saturation
  ppr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .displacement_i (displacement_i),
    .load_i         (load_i),
    .rearm_i        (rearm_i),
    .sts_o          (sts),
    .first_ratio_o  (first_ratio_o),
    .second_ratio_o (second_ratio_o)
  );

endmodule

// ----- rtl/ppr_checker.sv -----
// Port-level checker for the penetration point ratio unit, bound to the top level.
// Depends on ppr_pkg widths and penetration_point_ratio_unit_assert.svh macros.
`include "penetration_point_ratio_unit_assert.svh"

module ppr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [ppr_pkg::DataW-1:0]    displacement_i,
  input logic [ppr_pkg::DataW-1:0]    load_i,
  input logic                         rearm_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         first_valid_o,
  input logic [ppr_pkg::DataW-1:0]    first_ratio_o,
  input logic                         second_valid_o,
  input logic [ppr_pkg::DataW-1:0]    second_ratio_o,
  input logic                         all_found_o,
  input logic                         cfg_we_i,
  input logic [ppr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [ppr_pkg::CfgW-1:0]     cfg_wdata_i
);

  // stalled result holds
  `PPR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(first_ratio_o) && $stable(second_ratio_o) && $stable(first_valid_o) && $stable(second_valid_o) && $stable(all_found_o), "stalled result changed")

  // one item at a time: input side closes right after a transfer
  `PPR_ASSERT_NEXT(a_in_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")

  // a ratio without its depth crossing reads zero
  `PPR_ASSERT_IMPL(a_first_zero, clk_i, rst_ni, out_valid_o && !first_valid_o, first_ratio_o == 32'd0, "first ratio not zero")
  `PPR_ASSERT_IMPL(a_second_zero, clk_i, rst_ni, out_valid_o && !second_valid_o, second_ratio_o == 32'd0, "second ratio not zero")

endmodule

bind penetration_point_ratio_unit ppr_checker u_ppr_checker (.*);
